// File: rtl/fct_pkg.sv
// Shared constants and types for the frustum cull test block.
// No dependencies; fct_regs, fct_cell, frustum_cull_test and fct_checker import this package.
`default_nettype none

package fct_pkg;

    localparam int PLANE_COUNT = 6;
    localparam int PLANE_BITS  = 64;
    localparam int NORM_BITS   = 16;
    // Q1.14 normal times Q.4 coordinate gives Q.18; offsets and radii align by this shift
    localparam int D_SHIFT     = 14;
    localparam int D_LSB       = 48;
    localparam int PADDR_BITS  = 6;
    localparam int REG_IDX_LSB = 3;
    localparam int REG_IDX_BITS = 3;

    typedef enum logic [REG_IDX_BITS-1:0] {
        REG_PLANE_TOP    = 3'd0,
        REG_PLANE_LEFT   = 3'd1,
        REG_PLANE_NEAR   = 3'd2,
        REG_PLANE_RIGHT  = 3'd3,
        REG_PLANE_BOTTOM = 3'd4,
        REG_PLANE_FAR    = 3'd5
    } t_reg_idx;

    typedef logic [PLANE_COUNT-1:0][PLANE_BITS-1:0] t_planes;

endpackage

`default_nettype wire

// File: rtl/fct_item_if.sv
// Input channel of the frustum cull test: valid/ready plus one box or point word.
// Standalone; width follows COORD_BITS.
`default_nettype none

interface fct_item_if #(
    parameter int COORD_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic                         op;
    logic signed [COORD_BITS-1:0] min_x;
    logic signed [COORD_BITS-1:0] min_y;
    logic signed [COORD_BITS-1:0] min_z;
    logic signed [COORD_BITS-1:0] max_x;
    logic signed [COORD_BITS-1:0] max_y;
    logic signed [COORD_BITS-1:0] max_z;
    logic        [COORD_BITS-2:0] radius;

    modport source (
        output valid, op, min_x, min_y, min_z, max_x, max_y, max_z, radius,
        input  ready
    );
    modport sink (
        input  valid, op, min_x, min_y, min_z, max_x, max_y, max_z, radius,
        output ready
    );
endinterface

`default_nettype wire

// File: rtl/fct_res_if.sv
// Result channel of the frustum cull test: valid/ready plus the visible flag.
// Standalone.
`default_nettype none

interface fct_res_if;
    logic valid;
    logic ready;
    logic visible;

    modport source (
        output valid, visible,
        input  ready
    );
    modport sink (
        input  valid, visible,
        output ready
    );
endinterface

`default_nettype wire

// File: rtl/fct_regs.sv
// Plane register file behind the APB-style configuration port.
// Depends on fct_pkg.
`default_nettype none

module fct_regs import fct_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [PADDR_BITS-1:0] paddr,
    input  wire logic [PLANE_BITS-1:0] pwdata,
    output logic      [PLANE_BITS-1:0] prdata,
    output logic                       pready,
    output t_planes                    o_planes
);

    t_planes                  r_plane;
    logic [REG_IDX_BITS-1:0]  w_idx;
    logic                     w_idx_ok;
    logic                     w_wr;

    assign w_idx = paddr[REG_IDX_LSB +: REG_IDX_BITS];
    assign w_wr  = psel && penable && pwrite;

    always_comb begin
        unique case (t_reg_idx'(w_idx))
            REG_PLANE_TOP, REG_PLANE_LEFT, REG_PLANE_NEAR,
            REG_PLANE_RIGHT, REG_PLANE_BOTTOM, REG_PLANE_FAR: begin
                w_idx_ok = 1'b1;
            end
            default: begin
                w_idx_ok = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plane <= '0;
        end else if (w_wr && w_idx_ok) begin
            r_plane[w_idx] <= pwdata;
        end
    end

    assign prdata   = w_idx_ok ? r_plane[w_idx] : '0;
    assign pready   = 1'b1;
    assign o_planes = r_plane;

endmodule

`default_nettype wire

// File: rtl/fct_cell.sv
// One plane cell: picks the positive vertex, multiplies by the normal, then sums
// and compares against the radius threshold. Two pipeline stages. Depends on fct_pkg.
`default_nettype none

module fct_cell import fct_pkg::*; #(
    parameter int COORD_BITS = 16
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic [PLANE_BITS-1:0]            i_plane,
    input  wire logic                             i_valid,
    output logic                                  o_ready,
    input  wire logic                             i_op,
    input  wire logic [2:0][COORD_BITS-1:0]       i_lo,
    input  wire logic [2:0][COORD_BITS-1:0]       i_hi,
    input  wire logic [COORD_BITS-2:0]            i_rad,
    input  wire logic                             i_vis,
    output logic                                  o_valid,
    input  wire logic                             i_ready,
    output logic                                  o_op,
    output logic [2:0][COORD_BITS-1:0]            o_lo,
    output logic [2:0][COORD_BITS-1:0]            o_hi,
    output logic [COORD_BITS-2:0]                 o_rad,
    output logic                                  o_vis
);

    localparam int PW = COORD_BITS + NORM_BITS;
    localparam int SW = COORD_BITS + 20;

    // multiply stage
    logic                          r_a_valid;
    logic                          r_a_op;
    logic [2:0][COORD_BITS-1:0]    r_a_lo;
    logic [2:0][COORD_BITS-1:0]    r_a_hi;
    logic [COORD_BITS-2:0]         r_a_rad;
    logic                          r_a_vis;
    logic signed [PW-1:0]          r_a_prod [3];
    logic signed [NORM_BITS-1:0]   r_a_d;
    logic signed [PW-1:0]          n_a_prod [3];

    // sum and compare stage
    logic                          r_b_valid;
    logic                          r_b_op;
    logic [2:0][COORD_BITS-1:0]    r_b_lo;
    logic [2:0][COORD_BITS-1:0]    r_b_hi;
    logic [COORD_BITS-2:0]         r_b_rad;
    logic                          r_b_vis;

    logic                          w_a_ready;
    logic                          w_b_ready;
    logic [COORD_BITS-2:0]         w_rad_eff;
    logic signed [SW-1:0]          n_sum;

    assign w_b_ready = !r_b_valid || i_ready;
    assign w_a_ready = !r_a_valid || w_b_ready;
    assign o_ready   = w_a_ready;

    // box: max corner where the normal component is non-negative; point: the point itself
    always_comb begin
        logic signed [NORM_BITS-1:0]  v_n;
        logic signed [COORD_BITS-1:0] v_pt;
        for (int a = 0; a < 3; a++) begin
            v_n  = i_plane[a*NORM_BITS +: NORM_BITS];
            v_pt = (i_op || v_n[NORM_BITS-1]) ? i_lo[a] : i_hi[a];
            n_a_prod[a] = v_n * v_pt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_a_ready) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_a_ready) begin
            r_a_op   <= i_op;
            r_a_lo   <= i_lo;
            r_a_hi   <= i_hi;
            r_a_rad  <= i_rad;
            r_a_vis  <= i_vis;
            r_a_d    <= i_plane[D_LSB +: NORM_BITS];
            for (int a = 0; a < 3; a++) begin
                r_a_prod[a] <= n_a_prod[a];
            end
        end
    end

    // n.p + d, plus the radius for a point, all in Q.18; negative means culled by this plane
    assign w_rad_eff = r_a_op ? r_a_rad : '0;
    assign n_sum = SW'(r_a_prod[0]) + SW'(r_a_prod[1]) + SW'(r_a_prod[2])
                 + (SW'(r_a_d) <<< D_SHIFT)
                 + SW'({w_rad_eff, {D_SHIFT{1'b0}}});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (w_b_ready) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_b_ready) begin
            r_b_op  <= r_a_op;
            r_b_lo  <= r_a_lo;
            r_b_hi  <= r_a_hi;
            r_b_rad <= r_a_rad;
            r_b_vis <= r_a_vis && !n_sum[SW-1];
        end
    end

    assign o_valid = r_b_valid;
    assign o_op    = r_b_op;
    assign o_lo    = r_b_lo;
    assign o_hi    = r_b_hi;
    assign o_rad   = r_b_rad;
    assign o_vis   = r_b_vis;

endmodule

`default_nettype wire

// File: rtl/frustum_cull_test.sv
// Frustum cull test: each word (a box, or a point with a radius) passes along a row of
// six plane cells and comes out with a visible flag. One word is taken every cycle unless the
// result side stalls; each cell registers it in a multiply stage and then a sum and
// compare stage, and the last cell's register drives the result channel. A stall on the
// result side backs up only as far as the first free stage, so words keep entering while
// bubbles remain. Planes are written through the APB-style port (64-bit registers at
// 8-byte strides: top, left, near, right, bottom, far); write them only while idle.
// Depends on fct_pkg, fct_item_if, fct_res_if, fct_regs and fct_cell.
`default_nettype none

module frustum_cull_test import fct_pkg::*; #(
    parameter int COORD_BITS = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    fct_item_if.sink                   i_item,
    fct_res_if.source                  o_res,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [PADDR_BITS-1:0] paddr,
    input  wire logic [PLANE_BITS-1:0] pwdata,
    output logic      [PLANE_BITS-1:0] prdata,
    output logic                       pready
);

    t_planes                      w_planes;
    logic                         w_valid [PLANE_COUNT+1];
    logic                         w_ready [PLANE_COUNT+1];
    logic                         w_op    [PLANE_COUNT+1];
    logic [2:0][COORD_BITS-1:0]   w_lo    [PLANE_COUNT+1];
    logic [2:0][COORD_BITS-1:0]   w_hi    [PLANE_COUNT+1];
    logic [COORD_BITS-2:0]        w_rad   [PLANE_COUNT+1];
    logic                         w_vis   [PLANE_COUNT+1];

    fct_regs u_regs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_planes (w_planes)
    );

    assign w_valid[0] = i_item.valid;
    assign w_op[0]    = i_item.op;
    assign w_lo[0]    = {i_item.min_z, i_item.min_y, i_item.min_x};
    assign w_hi[0]    = {i_item.max_z, i_item.max_y, i_item.max_x};
    assign w_rad[0]   = i_item.radius;
    assign w_vis[0]   = 1'b1;
    assign i_item.ready = w_ready[0];

    for (genvar k = 0; k < PLANE_COUNT; k++) begin : g_cell
        fct_cell #(
            .COORD_BITS (COORD_BITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_plane (w_planes[k]),
            .i_valid (w_valid[k]),
            .o_ready (w_ready[k]),
            .i_op    (w_op[k]),
            .i_lo    (w_lo[k]),
            .i_hi    (w_hi[k]),
            .i_rad   (w_rad[k]),
            .i_vis   (w_vis[k]),
            .o_valid (w_valid[k+1]),
            .i_ready (w_ready[k+1]),
            .o_op    (w_op[k+1]),
            .o_lo    (w_lo[k+1]),
            .o_hi    (w_hi[k+1]),
            .o_rad   (w_rad[k+1]),
            .o_vis   (w_vis[k+1])
        );
    end

    assign o_res.valid   = w_valid[PLANE_COUNT];
    assign o_res.visible = w_vis[PLANE_COUNT];
    assign w_ready[PLANE_COUNT] = o_res.ready;

endmodule

`default_nettype wire

// File: rtl/fct_checker.sv
// Port-level checks for frustum_cull_test, attached by the bind at the end.
// Depends on fct_pkg.
`default_nettype none

module fct_checker import fct_pkg::*; (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_in_ready,
    input wire logic i_out_valid,
    input wire logic i_out_ready,
    input wire logic i_out_visible,
    input wire logic i_psel,
    input wire logic i_penable,
    input wire logic i_pwrite,
    input wire logic i_pready
);

    logic r_any_write;

    // note any plane write since reset; until then all planes are zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_any_write <= 1'b0;
        end else if (i_psel && i_penable && i_pwrite && i_pready) begin
            r_any_write <= 1'b1;
        end
    end

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    a_zero_planes_visible: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !r_any_write |-> i_out_visible)
        else $error("word culled by reset planes");

    a_empty_tail_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty output stage");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_visible))
        else $error("stalled result dropped or changed");

endmodule

bind frustum_cull_test fct_checker u_fct_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_ready    (i_item.ready),
    .i_out_valid   (o_res.valid),
    .i_out_ready   (o_res.ready),
    .i_out_visible (o_res.visible),
    .i_psel        (psel),
    .i_penable     (penable),
    .i_pwrite      (pwrite),
    .i_pready      (pready)
);

`default_nettype wire
